FILE: hw/rtl/bpra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator package
// Shared sizes, configuration and payload types, controller state and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

  // Pages per pool. It must be a power of two and a multiple of WORD_W.
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;

  // The bitmaps are kept as words of WORD_W pages.
  localparam int WORD_W     = 32;
  localparam int BIT_IDX_W  = $clog2(WORD_W);
  localparam int POOL_WORDS = MAX_PAGES / WORD_W;
  localparam int WORD_IDX_W = $clog2(POOL_WORDS);
  localparam int MEM_AW     = WORD_IDX_W + 1;
  localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
  localparam int LEN_W      = $clog2(MAX_PAGES + 1);

  // Field widths of the ports.
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 13;
  localparam int FIRST_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [ADDR_W-1:0]  KERNEL_BASE_RST = 32'hC010_0000;
  localparam logic [ADDR_W-1:0]  USER_BASE_RST   = 32'h0000_0000;
  localparam logic [COUNT_W-1:0] PAGES_RST       = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_BASE  = 3'd0,
    CFG_USER_BASE    = 3'd1,
    CFG_KERNEL_PAGES = 3'd2,
    CFG_USER_PAGES   = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  kernel_base;
    logic [ADDR_W-1:0]  user_base;
    logic [COUNT_W-1:0] kernel_pages;
    logic [COUNT_W-1:0] user_pages;
  } cfg_t;

  typedef struct packed {
    logic               pool;
    logic [COUNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [ADDR_W-1:0]  base_address;
    logic [FIRST_W-1:0] first_page;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan_start;
    logic scan;
    logic mark_start;
    logic mark;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_bad;
    logic hit;
    logic scan_last;
    logic mark_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpra_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator controller
// Sequences the clearing sweep, the first-fit scan, the marking pass and the
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_ctrl import bpra_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.req_bad ? ST_RESP : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = ST_MARK_RD;
        end else if (stat_i.scan_last) begin
          state_d = ST_RESP;
        end
      end
      ST_MARK_RD: begin
        state_d = ST_MARK;
      end
      ST_MARK: begin
        if (stat_i.mark_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.scan_start = !stat_i.req_bad;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_MARK_RD: begin
        cmd_o.mark_start = 1'b1;
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
      end
      ST_RESP: begin
        cmd_o.resp = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bpra_dp.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator datapath
// Holds both bitmaps in one word memory, runs the word-per-cycle first-fit
// search, sets the bits of a found run and keeps the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_dp import bpra_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  output stat_t     stat_o,
  input  wire req_t req_i,
  input  wire cfg_t cfg_i,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output rsp_t      out_data_o
);

  localparam int MEM_WORDS = 2 * POOL_WORDS;

  // Kernel pool in the lower half, user pool in the upper half.
  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [MEM_AW-1:0] raddr;
  logic [MEM_AW-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              we;

  // Control registers.
  logic [MEM_AW-1:0] ptr_q;
  logic              found_q;
  logic              out_valid_q;

  // Request and search registers.
  logic                  pool_q;
  logic [COUNT_W-1:0]    count_q;
  logic [LEN_W-1:0]      len_q;
  logic [ADDR_W-1:0]     base_q;
  logic [WORD_IDX_W-1:0] word_q;
  logic [LEN_W-1:0]      carry_q;
  logic [PAGE_IDX_W-1:0] end_q;
  logic [PAGE_IDX_W-1:0] start_q;
  rsp_t                  out_q;

  logic [COUNT_W-1:0]    sel_pages;
  logic [LEN_W-1:0]      len_d;
  logic [LEN_W-1:0]      len_m1;
  logic [WORD_IDX_W-1:0] last_word;
  logic [WORD_W-1:0]     free_w;
  logic [LEN_W-1:0]      run_len [WORD_W];
  logic [WORD_W-1:0]     hit_vec;
  logic                  hit_any;
  logic [BIT_IDX_W-1:0]  hit_idx;
  logic [31:0]           start_sum;
  logic [PAGE_IDX_W-1:0] start_w;
  logic [WORD_W-1:0]     lo_mask;
  logic [WORD_W-1:0]     hi_mask;
  logic [WORD_W-1:0]     run_mask;

  // A pages register above capacity acts as the capacity.
  assign sel_pages = req_i.pool ? cfg_i.user_pages : cfg_i.kernel_pages;
  assign len_d     = (32'(sel_pages) > 32'(MAX_PAGES)) ? LEN_W'(MAX_PAGES)
                                                       : LEN_W'(sel_pages);
  assign len_m1    = len_q - LEN_W'(1);
  assign last_word = len_m1[PAGE_IDX_W-1:BIT_IDX_W];

  // Pages at or beyond the pool length count as used.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      free_w[j] = !rdata_q[j] && (32'({word_q, BIT_IDX_W'(j)}) < 32'(len_q));
    end
  end

  // Length of the free run that ends at each bit of the current word.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      run_len[j] = carry_q + LEN_W'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (!free_w[k]) run_len[j] = LEN_W'(j - k);
      end
      hit_vec[j] = 32'(run_len[j]) >= 32'(count_q);
    end
  end

  always_comb begin
    hit_any = |hit_vec;
    hit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_vec[j]) hit_idx = BIT_IDX_W'(j);
    end
  end

  assign start_sum = 32'(end_q) + 32'd1 - 32'(count_q);
  assign start_w   = start_sum[PAGE_IDX_W-1:0];

  // Bits of the current word that fall inside the found run.
  assign lo_mask  = (word_q == start_q[PAGE_IDX_W-1:BIT_IDX_W])
                  ? ({WORD_W{1'b1}} << start_q[BIT_IDX_W-1:0]) : {WORD_W{1'b1}};
  assign hi_mask  = (word_q == end_q[PAGE_IDX_W-1:BIT_IDX_W])
                  ? ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - end_q[BIT_IDX_W-1:0]))
                  : {WORD_W{1'b1}};
  assign run_mask = lo_mask & hi_mask;

  always_comb begin
    if (cmd_i.scan_start) begin
      raddr = {pool_q, WORD_IDX_W'(0)};
    end else if (cmd_i.mark_start) begin
      raddr = {pool_q, start_w[PAGE_IDX_W-1:BIT_IDX_W]};
    end else begin
      raddr = {pool_q, word_q + WORD_IDX_W'(1)};
    end
  end

  assign we    = cmd_i.clear || cmd_i.mark;
  assign waddr = cmd_i.clear ? ptr_q : {pool_q, word_q};
  assign wdata = cmd_i.clear ? '0 : (rdata_q | run_mask);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) ptr_q <= ptr_q + MEM_AW'(1);
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan && hit_any) begin
        found_q <= 1'b1;
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pool_q  <= req_i.pool;
      count_q <= req_i.page_count;
      len_q   <= len_d;
      base_q  <= req_i.pool ? cfg_i.user_base : cfg_i.kernel_base;
    end
    if (cmd_i.scan_start) begin
      word_q  <= '0;
      carry_q <= '0;
    end else if (cmd_i.scan) begin
      word_q  <= word_q + WORD_IDX_W'(1);
      carry_q <= run_len[WORD_W-1];
      if (hit_any) end_q <= {word_q, hit_idx};
    end else if (cmd_i.mark_start) begin
      word_q  <= start_w[PAGE_IDX_W-1:BIT_IDX_W];
      start_q <= start_w;
    end else if (cmd_i.mark) begin
      word_q  <= word_q + WORD_IDX_W'(1);
    end
    if (cmd_i.resp) begin
      if (found_q) begin
        out_q.granted      <= 1'b1;
        out_q.base_address <= base_q + (ADDR_W'(start_q) << PAGE_SHIFT);
        out_q.first_page   <= FIRST_W'(start_q);
      end else begin
        out_q <= '0;
      end
    end
  end

  assign stat_o.clear_last = (ptr_q == {MEM_AW{1'b1}});
  assign stat_o.req_bad    = (count_q == '0) || (32'(count_q) > 32'(len_q));
  assign stat_o.hit        = hit_any;
  assign stat_o.scan_last  = (word_q == last_word);
  assign stat_o.mark_last  = (word_q == end_q[PAGE_IDX_W-1:BIT_IDX_W]);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A run only ever covers pages that were free when it was found.
  a_mark_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> ((rdata_q & run_mask) == '0))
    else $error("marking a page that is already in use");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A hit during the scan leads to a granted result.
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && hit_any) |=> found_q)
    else $error("hit not recorded");

  // A refused request reports a zero address and page.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.granted) |->
      (out_q.base_address == '0 && out_q.first_page == '0))
    else $error("refused request carries nonzero fields");

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_page_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit allocation of contiguous page runs from a kernel and a user pool.
// ----------------------------------------------------------------------------
// A request for zero pages or more than the pool length is refused without
// a scan. Otherwise the scan reads the 32-page bitmap words of the pool in
// order (up to 128) until a run fits, and a found run is then marked in the
// words that it touches before the result is registered for output.
// One item is in work at a time, and the single word memory port pair
// paces both the scan and the marking.
// After reset, a sweep clears all 256 bitmap words before the first item.
`default_nettype none

module bitmap_page_run_allocator import bpra_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire req_t                 in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rsp_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_base  <= KERNEL_BASE_RST;
      cfg_q.user_base    <= USER_BASE_RST;
      cfg_q.kernel_pages <= PAGES_RST;
      cfg_q.user_pages   <= PAGES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KERNEL_BASE:  cfg_q.kernel_base  <= cfg_data_i;
        CFG_USER_BASE:    cfg_q.user_base    <= cfg_data_i;
        CFG_KERNEL_PAGES: cfg_q.kernel_pages <= cfg_data_i[COUNT_W-1:0];
        CFG_USER_PAGES:   cfg_q.user_pages   <= cfg_data_i[COUNT_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  bpra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (in_data_i),
    .cfg_i       (cfg_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
